@@ hw/rtl/hmh_pkg.sv @@
// Shared types and constants for the hillshade pixel unit.
// No dependencies; the four modules import this package.
package hmh_pkg;

	localparam int COORD_W  = 9;
	localparam int PADDR_W  = 5;
	localparam int ACC_W    = 43;
	localparam int SUM_W    = 42;
	localparam int IB_W     = 58;
	localparam int CHP_W    = 45;
	localparam int T_W      = 38;

	localparam logic [T_W-1:0] T_SAT     = 38'd65025;
	localparam logic [15:0]    RECIP_255 = 16'h8081;

	localparam logic [1:0]  RST_MODE   = 2'd0;
	localparam logic [23:0] RST_COEF_X = 24'd23170;
	localparam logic [23:0] RST_COEF_Y = 24'd23170;
	localparam logic [23:0] RST_FLAT   = 24'd32768;
	localparam logic [15:0] RST_BRIGHT = 16'd256;
	localparam logic [23:0] RST_LIGHT  = 24'hffffff;
	localparam logic [8:0]  RST_WIDTH  = 9'd256;
	localparam logic [8:0]  RST_HEIGHT = 9'd256;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_COEF_X,
		REG_COEF_Y,
		REG_COEF_FLAT,
		REG_BRIGHT,
		REG_LIGHT,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_SHADE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		NB_C,
		NB_L,
		NB_R,
		NB_D,
		NB_U
	} nb_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR,
		ST_RDL,
		ST_RDR,
		ST_RDD,
		ST_RDU,
		ST_DY,
		ST_MY,
		ST_BLO,
		ST_BHI,
		ST_CLO,
		ST_CHI,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]  mode_flags;
		logic [23:0] coef_x;
		logic [23:0] coef_y;
		logic [23:0] coef_flat;
		logic [15:0] brightness;
		logic [23:0] light_rgb;
		logic [8:0]  map_width;
		logic [8:0]  map_height;
	} cfg_t;

	typedef struct packed {
		logic        operation;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [15:0] elevation;
		logic [7:0]  src_red;
		logic [7:0]  src_green;
		logic [7:0]  src_blue;
		logic [7:0]  src_alpha;
	} req_t;

	typedef struct packed {
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
		logic [7:0] pix_alpha;
	} pix_t;

	typedef struct packed {
		logic capture;
		logic mem_wr;
		nb_t  rd_sel;
		logic lat_a;
		logic lat_dx;
		logic lat_dy;
		logic mac_x;
		logic mac_y;
		logic ib_lo;
		logic ib_hi;
		logic ch_lo;
		logic ch_hi;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic req_shade;
		logic light_on;
		logic out_blocked;
	} sts_t;

endpackage

@@ hw/rtl/hmh_req_if.sv @@
// Request channel: valid/ready plus the load/shade request fields.
// No dependencies.
interface hmh_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  col;
	logic [7:0]  row;
	logic signed [15:0] elevation;
	logic [7:0]  src_red;
	logic [7:0]  src_green;
	logic [7:0]  src_blue;
	logic [7:0]  src_alpha;

	modport source (
		output valid, operation, col, row, elevation,
		output src_red, src_green, src_blue, src_alpha,
		input  ready
	);
	modport sink (
		input  valid, operation, col, row, elevation,
		input  src_red, src_green, src_blue, src_alpha,
		output ready
	);
endinterface

@@ hw/rtl/hmh_pix_if.sv @@
// Result channel: valid/ready plus the shaded RGBA pixel.
// No dependencies.
interface hmh_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pix_red;
	logic [7:0] pix_green;
	logic [7:0] pix_blue;
	logic [7:0] pix_alpha;

	modport source (
		output valid, pix_red, pix_green, pix_blue, pix_alpha,
		input  ready
	);
	modport sink (
		input  valid, pix_red, pix_green, pix_blue, pix_alpha,
		output ready
	);
endinterface

@@ hw/rtl/hmh_regs.sv @@
// APB register file for the hillshade configuration.
// Depends on hmh_pkg.
module hmh_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hmh_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output hmh_pkg::cfg_t               cfg
);
	import hmh_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_flags <= RST_MODE;
			cfg_q.coef_x     <= RST_COEF_X;
			cfg_q.coef_y     <= RST_COEF_Y;
			cfg_q.coef_flat  <= RST_FLAT;
			cfg_q.brightness <= RST_BRIGHT;
			cfg_q.light_rgb  <= RST_LIGHT;
			cfg_q.map_width  <= RST_WIDTH;
			cfg_q.map_height <= RST_HEIGHT;
		end else if (wr_en) begin
			case (idx)
				REG_MODE:      cfg_q.mode_flags <= pwdata[1:0];
				REG_COEF_X:    cfg_q.coef_x     <= pwdata[23:0];
				REG_COEF_Y:    cfg_q.coef_y     <= pwdata[23:0];
				REG_COEF_FLAT: cfg_q.coef_flat  <= pwdata[23:0];
				REG_BRIGHT:    cfg_q.brightness <= pwdata[15:0];
				REG_LIGHT:     cfg_q.light_rgb  <= pwdata[23:0];
				REG_WIDTH:     cfg_q.map_width  <= pwdata[8:0];
				REG_HEIGHT:    cfg_q.map_height <= pwdata[8:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:      prdata = {30'd0, cfg_q.mode_flags};
			REG_COEF_X:    prdata = {8'd0, cfg_q.coef_x};
			REG_COEF_Y:    prdata = {8'd0, cfg_q.coef_y};
			REG_COEF_FLAT: prdata = {8'd0, cfg_q.coef_flat};
			REG_BRIGHT:    prdata = {16'd0, cfg_q.brightness};
			REG_LIGHT:     prdata = {8'd0, cfg_q.light_rgb};
			REG_WIDTH:     prdata = {23'd0, cfg_q.map_width};
			REG_HEIGHT:    prdata = {23'd0, cfg_q.map_height};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

@@ hw/rtl/hmh_ctrl.sv @@
// Sequencer for load and shade requests; drives datapath commands.
// Depends on hmh_pkg.
module hmh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  hmh_pkg::sts_t sts,
	output logic          req_ready,
	output hmh_pkg::cmd_t cmd
);
	import hmh_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		cmd.rd_sel = NB_C;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (!sts.req_shade) begin
						state_nxt = ST_WR;
					end else if (sts.light_on) begin
						state_nxt = ST_RDL;
					end else begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_WR: begin
				cmd.mem_wr = 1'b1;
				state_nxt  = ST_IDLE;
			end
			ST_RDL: begin
				cmd.rd_sel = NB_L;
				state_nxt  = ST_RDR;
			end
			ST_RDR: begin
				cmd.rd_sel = NB_R;
				cmd.lat_a  = 1'b1;
				state_nxt  = ST_RDD;
			end
			ST_RDD: begin
				cmd.rd_sel = NB_D;
				cmd.lat_dx = 1'b1;
				state_nxt  = ST_RDU;
			end
			ST_RDU: begin
				cmd.rd_sel = NB_U;
				cmd.lat_a  = 1'b1;
				cmd.mac_x  = 1'b1;
				state_nxt  = ST_DY;
			end
			ST_DY: begin
				cmd.lat_dy = 1'b1;
				state_nxt  = ST_MY;
			end
			ST_MY: begin
				cmd.mac_y = 1'b1;
				state_nxt = ST_BLO;
			end
			ST_BLO: begin
				cmd.ib_lo = 1'b1;
				state_nxt = ST_BHI;
			end
			ST_BHI: begin
				cmd.ib_hi = 1'b1;
				state_nxt = ST_CLO;
			end
			ST_CLO: begin
				cmd.ch_lo = 1'b1;
				state_nxt = ST_CHI;
			end
			ST_CHI: begin
				cmd.ch_hi = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_blocked) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_load_goes_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture && !sts.req_shade |=> state_q == ST_WR)
		else $error("load transfer did not enter write state");

	a_shade_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture && sts.req_shade && sts.light_on |=> ##10 state_q == ST_FIN)
		else $error("lit shade sequence length wrong");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && sts.out_blocked |=> state_q == ST_FIN)
		else $error("left finish state while output stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sts.out_blocked |-> !cmd.out_load)
		else $error("result register overwritten before transfer");

endmodule

@@ hw/rtl/hmh_dpath.sv @@
// Datapath: height memory, neighbor addressing, slope MAC, brightness and
// per-channel scaling, output register. Depends on hmh_pkg.
module hmh_dpath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hmh_pkg::cfg_t cfg,
	input  hmh_pkg::req_t req,
	input  hmh_pkg::cmd_t cmd,
	input  logic          pix_ready,
	output hmh_pkg::sts_t sts,
	output hmh_pkg::pix_t pix,
	output logic          pix_valid
);
	import hmh_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [COORD_W-1:0] w_eff, h_eff, w_last, h_last;
	logic [COORD_W-1:0] col_ext, row_ext;
	logic [COORD_W-1:0] x_q, y_q, xl, xr, yd, yu, nx, ny;
	logic               wrap;
	logic [AW-1:0]      addr;

	logic               ld_ok_q, light_q;
	logic [15:0]        elev_q;
	logic [7:0]         src_q [4];
	logic [15:0]        prod_q [3];
	logic [7:0]         lgt [3];
	logic [15:0]        prod_nxt [3];

	logic [15:0]        hgt_mem_q [DEPTH];
	logic signed [15:0] rd_q, ha_q;
	logic signed [16:0] dx_q, dy_q;
	logic signed [40:0] mx_prod, my_prod;
	logic signed [ACC_W-1:0] acc_q, flat_ext;
	logic [SUM_W-1:0]   sum_pos;
	logic [20:0]        ib_sel;
	logic [36:0]        ib_prod;
	logic [IB_W-1:0]    ib_q;
	logic [28:0]        ch_op;
	logic [CHP_W-1:0]   chp [3];
	logic [CHP_W-1:0]   ch_up [3];
	logic [CHP_W-1:0]   lo_q [3];
	logic [T_W-1:0]     t_q [3];
	logic [31:0]        q255 [3];
	logic [7:0]         chv [3];

	pix_t pix_q;
	logic pix_valid_q;

	always_comb begin
		if (cfg.map_width == '0) begin
			w_eff = COORD_W'(1);
		end else if (32'(cfg.map_width) > 32'(MAX_WIDTH)) begin
			w_eff = COORD_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg.map_width;
		end
		if (cfg.map_height == '0) begin
			h_eff = COORD_W'(1);
		end else if (32'(cfg.map_height) > 32'(MAX_HEIGHT)) begin
			h_eff = COORD_W'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.map_height;
		end
	end

	assign w_last  = w_eff - COORD_W'(1);
	assign h_last  = h_eff - COORD_W'(1);
	assign col_ext = {1'b0, req.col};
	assign row_ext = {1'b0, req.row};
	assign wrap    = cfg.mode_flags[1];

	assign lgt[0] = cfg.light_rgb[23:16];
	assign lgt[1] = cfg.light_rgb[15:8];
	assign lgt[2] = cfg.light_rgb[7:0];
	assign prod_nxt[0] = req.src_red * lgt[0];
	assign prod_nxt[1] = req.src_green * lgt[1];
	assign prod_nxt[2] = req.src_blue * lgt[2];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_ok_q  <= (col_ext < w_eff) && (row_ext < h_eff);
			x_q      <= (col_ext >= w_eff) ? w_last : col_ext;
			y_q      <= (row_ext >= h_eff) ? h_last : row_ext;
			elev_q   <= req.elevation;
			light_q  <= cfg.mode_flags[0];
			src_q[0] <= req.src_red;
			src_q[1] <= req.src_green;
			src_q[2] <= req.src_blue;
			src_q[3] <= req.src_alpha;
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= prod_nxt[i];
			end
		end
	end

	// neighbor coordinates, edge reuse or wrap
	always_comb begin
		xl = (x_q == '0) ? (wrap ? w_last : x_q) : x_q - COORD_W'(1);
		xr = (x_q == w_last) ? (wrap ? '0 : x_q) : x_q + COORD_W'(1);
		yd = (y_q == '0) ? (wrap ? h_last : y_q) : y_q - COORD_W'(1);
		yu = (y_q == h_last) ? (wrap ? '0 : y_q) : y_q + COORD_W'(1);
		case (cmd.rd_sel)
			NB_L: begin
				nx = xl;
				ny = y_q;
			end
			NB_R: begin
				nx = xr;
				ny = y_q;
			end
			NB_D: begin
				nx = x_q;
				ny = yd;
			end
			NB_U: begin
				nx = x_q;
				ny = yu;
			end
			default: begin
				nx = x_q;
				ny = y_q;
			end
		endcase
	end

	assign addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && ld_ok_q) begin
			hgt_mem_q[addr] <= elev_q;
		end
		rd_q <= hgt_mem_q[addr];
	end

	assign mx_prod  = $signed(cfg.coef_x) * dx_q;
	assign my_prod  = $signed(cfg.coef_y) * dy_q;
	assign flat_ext = {{7{cfg.coef_flat[23]}}, cfg.coef_flat, 12'd0};
	assign sum_pos  = acc_q[ACC_W-1] ? '0 : acc_q[SUM_W-1:0];
	assign ib_sel   = cmd.ib_hi ? sum_pos[41:21] : sum_pos[20:0];
	assign ib_prod  = ib_sel * cfg.brightness;

	always_ff @(posedge clk) begin
		if (cmd.lat_a) begin
			ha_q <= rd_q;
		end
		if (cmd.lat_dx) begin
			dx_q <= 17'(ha_q) - 17'(rd_q);
		end
		if (cmd.lat_dy) begin
			dy_q <= 17'(ha_q) - 17'(rd_q);
		end
		if (cmd.mac_x) begin
			acc_q <= flat_ext + {{2{mx_prod[40]}}, mx_prod};
		end else if (cmd.mac_y) begin
			acc_q <= acc_q + {{2{my_prod[40]}}, my_prod};
		end
		if (cmd.ib_lo) begin
			ib_q <= {21'd0, ib_prod};
		end else if (cmd.ib_hi) begin
			ib_q <= ib_q + {ib_prod, 21'd0};
		end
	end

	// per-channel floor(p*ib / 2^36), two partial products
	assign ch_op = cmd.ch_hi ? ib_q[57:29] : ib_q[28:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			chp[i]   = prod_q[i] * ch_op;
			ch_up[i] = chp[i] + {29'd0, lo_q[i][44:29]};
			q255[i]  = t_q[i][15:0] * RECIP_255;
			chv[i]   = (t_q[i] >= T_SAT) ? 8'hff : q255[i][30:23];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.ch_lo) begin
				lo_q[i] <= chp[i];
			end
			if (cmd.ch_hi) begin
				t_q[i] <= ch_up[i][44:7];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pix_q.pix_red   <= light_q ? chv[0] : src_q[0];
			pix_q.pix_green <= light_q ? chv[1] : src_q[1];
			pix_q.pix_blue  <= light_q ? chv[2] : src_q[2];
			pix_q.pix_alpha <= src_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	assign pix       = pix_q;
	assign pix_valid = pix_valid_q;

	assign sts.req_shade   = (req.operation == OP_SHADE);
	assign sts.light_on    = cfg.mode_flags[0];
	assign sts.out_blocked = pix_valid_q && !pix_ready;

endmodule

@@ hw/rtl/height_map_hillshade_pixel_unit.sv @@
// Hillshade pixel unit: a height store loaded point by point over the req
// channel (operation load) and lit RGBA shading of one point (operation shade).
// Configuration is written over the APB port while no request is in flight:
// the user must keep to this, as the block does not enforce it. req and pix
// are valid/ready channels; a transfer happens when both are high. A load
// gives no result; it is dropped when col or row lies outside the map size
// in use. A shade with lighting off goes straight to the finish state and
// gives its pixel from the output register. A lit shade reads four neighbor
// heights from the single-port height memory one per cycle, then runs the
// slope multiply-accumulate, brightness and channel scaling steps in
// sequence, and the unit takes one request at a time.
// The finished pixel sits in an output register; the next request is taken
// while it waits. If pix stalls, the unit holds its next result until the
// register drains.
// Reset restores register defaults and idles the sequencer; the height memory
// is not cleared and reads of never-written points are undefined.
// Depends on hmh_pkg, hmh_req_if, hmh_pix_if, hmh_regs, hmh_ctrl, hmh_dpath.
module height_map_hillshade_pixel_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hmh_req_if.sink                     req,
	hmh_pix_if.source                   pix,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hmh_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import hmh_pkg::*;

	cfg_t cfg;
	req_t req_pl;
	pix_t pix_pl;
	cmd_t cmd;
	sts_t sts;
	logic req_ready;
	logic pix_valid;

	assign req_pl.operation = req.operation;
	assign req_pl.col       = req.col;
	assign req_pl.row       = req.row;
	assign req_pl.elevation = req.elevation;
	assign req_pl.src_red   = req.src_red;
	assign req_pl.src_green = req.src_green;
	assign req_pl.src_blue  = req.src_blue;
	assign req_pl.src_alpha = req.src_alpha;

	assign req.ready     = req_ready;
	assign pix.valid     = pix_valid;
	assign pix.pix_red   = pix_pl.pix_red;
	assign pix.pix_green = pix_pl.pix_green;
	assign pix.pix_blue  = pix_pl.pix_blue;
	assign pix.pix_alpha = pix_pl.pix_alpha;

	hmh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	hmh_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req_pl),
		.cmd       (cmd),
		.pix_ready (pix.ready),
		.sts       (sts),
		.pix       (pix_pl),
		.pix_valid (pix_valid)
	);

endmodule
